// ===== rtl/core/chm_pkg.sv =====
package chm_pkg;

  // Default sizes of the map.
  localparam int CAPACITY_DEF   = 1024;
  localparam int BUCKETS_DEF    = 512;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Configuration register indexes.
  localparam logic CFG_CAPACITY  = 1'b0;
  localparam logic CFG_KEY_BYTES = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [10:0] CAP_LIMIT_RST = 11'd1024;
  localparam logic [3:0]  KEY_BYTES_RST = 4'd8;

  // Function codes on the input channel.
  localparam logic [2:0] FUNC_FIND  = 3'd0;
  localparam logic [2:0] FUNC_ADD   = 3'd1;
  localparam logic [2:0] FUNC_FIRST = 3'd2;
  localparam logic [2:0] FUNC_NEXT  = 3'd3;
  localparam logic [2:0] FUNC_CLEAR = 3'd4;

  // Operation classes handed from the front to the back.
  typedef enum logic [2:0] {
    OP_FIND,
    OP_ADD,
    OP_FIRST,
    OP_NEXT,
    OP_CLEAR,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] key;
    logic [31:0] value_in;
  } chm_in_t;

  typedef struct packed {
    logic        status;
    logic        found;
    logic [63:0] key_out;
    logic [31:0] value_out;
    logic [10:0] count;
  } chm_out_t;

  // Classified command; key is already masked, bucket already hashed.
  typedef struct packed {
    op_t         op;
    logic [63:0] key;
    logic [63:0] value;
    logic [15:0] bucket;
  } chm_cmd_t;

endpackage

// ===== rtl/core/chm_ram.sv =====
module chm_ram import chm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/chm_front.sv =====
module chm_front import chm_pkg::*; #(
  parameter int BUCKETS  = BUCKETS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  chm_in_t  in_data,
  input  logic [3:0] key_bytes,
  input  logic     clearing,
  output logic     cmd_valid,
  output chm_cmd_t cmd,
  input  logic     cmd_pop
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [BW:0] BKT_N = (BW + 1)'(BUCKETS);

  logic [3:0]          kb;
  logic [63:0]         kmask;
  logic [KEY_BITS-1:0] key_k;
  logic [BW-1:0]       fold;
  logic [BW:0]         fold_x;
  logic [BW:0]         bkt;
  chm_cmd_t            new_cmd;
  chm_cmd_t            slot [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          fill;
  logic                push;

  // Clamp the key width and build the byte mask.
  always_comb begin
    if (key_bytes == 4'd0) begin
      kb = 4'd1;
    end else if (key_bytes > 4'd8) begin
      kb = 4'd8;
    end else begin
      kb = key_bytes;
    end
    for (int i = 0; i < 64; i++) begin
      kmask[i] = (4'(i / 8) < kb);
    end
    key_k = KEY_BITS'(in_data.key & kmask);
  end

  // Bucket index: XOR fold of the stored key, brought below the bucket count.
  always_comb begin
    fold = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      fold[i % BW] = fold[i % BW] ^ key_k[i];
    end
    fold_x = {1'b0, fold};
    bkt = (fold_x >= BKT_N) ? (fold_x - BKT_N) : fold_x;
  end

  // Classify the function code.
  always_comb begin
    new_cmd.key    = 64'(key_k);
    new_cmd.value  = 64'(in_data.value_in);
    new_cmd.bucket = 16'(bkt[BW-1:0]);
    unique case (in_data.func)
      FUNC_FIND:  new_cmd.op = OP_FIND;
      FUNC_ADD:   new_cmd.op = OP_ADD;
      FUNC_FIRST: new_cmd.op = OP_FIRST;
      FUNC_NEXT:  new_cmd.op = OP_NEXT;
      FUNC_CLEAR: new_cmd.op = OP_CLEAR;
      default:    new_cmd.op = OP_NONE;
    endcase
  end

  // Two-entry command queue between front and back.
  assign in_ready  = (fill != 2'd2) && !clearing;
  assign push      = in_valid && in_ready;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !cmd_pop) begin
        fill <= fill + 2'd1;
      end else if (!push && cmd_pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= new_cmd;
    end
  end

endmodule

// ===== rtl/core/chm_back.sv =====
module chm_back import chm_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int BUCKETS    = BUCKETS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_clear,
  input  logic [10:0] capacity_limit,
  input  logic        cmd_valid,
  input  chm_cmd_t    q_cmd,
  output logic        cmd_pop,
  output logic        clearing,
  output logic        out_valid,
  input  logic        out_ready,
  output chm_out_t    out_data
);

  localparam int IDX_W = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);
  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int EW    = KEY_BITS + VALUE_BITS + IDX_W;
  localparam logic [IDX_W-1:0] NO_ENTRY = IDX_W'(CAPACITY);
  localparam logic [BW-1:0]    LAST_BKT = BW'(BUCKETS - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_HEAD  = 6'b000100,
    ST_WALK  = 6'b001000,
    ST_ITER  = 6'b010000,
    ST_RESP  = 6'b100000
  } back_state_t;

  back_state_t         state;
  chm_cmd_t            cmd;
  chm_out_t            res;
  logic [IDX_W-1:0]    total;
  logic [IDX_W-1:0]    iter;
  logic [IDX_W-1:0]    head;
  logic [BW-1:0]       sweep;
  logic                clr_resp;

  logic [IDX_W-1:0]    bkt_rdata;
  logic [EW-1:0]       e_rdata;
  logic [KEY_BITS-1:0] ent_key;
  logic [VALUE_BITS-1:0] ent_val;
  logic [IDX_W-1:0]    ent_link;
  logic [IDX_W-1:0]    head_now;
  logic [IDX_W-1:0]    walk_next;
  logic                walk_go;
  logic                hit;
  logic                full;
  logic                do_add;
  logic [16:0]         lim;
  logic                res_send;

  logic                b_we;
  logic [BW-1:0]       b_waddr;
  logic [IDX_W-1:0]    b_wdata;
  logic                e_we;
  logic [EW-1:0]       e_wdata;
  logic [AW-1:0]       e_raddr;

  assign ent_key  = e_rdata[EW-1 -: KEY_BITS];
  assign ent_val  = e_rdata[IDX_W +: VALUE_BITS];
  assign ent_link = e_rdata[IDX_W-1:0];
  assign clearing = (state == ST_CLEAR);
  assign cmd_pop  = (state == ST_IDLE) && cmd_valid && !cfg_clear;
  assign res_send = (state == ST_RESP) && !cfg_clear && (!out_valid || out_ready);

  // Chain walk decisions and memory controls.
  always_comb begin
    lim = (17'(capacity_limit) > 17'(CAPACITY)) ? 17'(CAPACITY) : 17'(capacity_limit);
    full = (17'(total) >= lim);
    head_now  = (state == ST_HEAD) ? bkt_rdata : head;
    walk_next = (state == ST_HEAD) ? bkt_rdata : ent_link;
    walk_go   = (walk_next < total);
    hit       = (state == ST_WALK) && (ent_key == cmd.key[KEY_BITS-1:0]);
    do_add    = ((state == ST_HEAD) || (state == ST_WALK)) && !hit && !walk_go &&
                (cmd.op == OP_ADD) && !full;

    e_we    = do_add;
    e_wdata = {cmd.key[KEY_BITS-1:0], cmd.value[VALUE_BITS-1:0], head_now};

    b_we    = clearing || do_add;
    b_waddr = clearing ? sweep : cmd.bucket[BW-1:0];
    b_wdata = clearing ? NO_ENTRY : total;

    if (state == ST_IDLE) begin
      e_raddr = (q_cmd.op == OP_FIRST) ? '0 : iter[AW-1:0];
    end else begin
      e_raddr = walk_next[AW-1:0];
    end
  end

  chm_ram #(.WIDTH(IDX_W), .DEPTH(BUCKETS)) u_bucket_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (q_cmd.bucket[BW-1:0]),
    .rdata (bkt_rdata)
  );

  chm_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (total[AW-1:0]),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  // Sequencer: bucket sweep, chain walk, iteration and result hand-off.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep     <= '0;
      clr_resp  <= 1'b0;
      total     <= '0;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      // Output register: load a finished result, or empty it after a transfer.
      if (res_send) begin
        out_valid <= 1'b1;
        out_data  <= {res.status, res.found, res.key_out, res.value_out, 11'(total)};
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_clear) begin
        total    <= '0;
        iter     <= '0;
        sweep    <= '0;
        clr_resp <= 1'b0;
        state    <= ST_CLEAR;
      end else begin
        unique case (state)
          ST_CLEAR: begin
            if (sweep == LAST_BKT) begin
              state <= clr_resp ? ST_RESP : ST_IDLE;
            end else begin
              sweep <= sweep + 1'b1;
            end
          end
          ST_IDLE: begin
            if (cmd_valid) begin
              cmd <= q_cmd;
              res <= '0;
              unique case (q_cmd.op)
                OP_FIND, OP_ADD: begin
                  state <= ST_HEAD;
                end
                OP_FIRST: begin
                  if (total == '0) begin
                    iter  <= '0;
                    state <= ST_RESP;
                  end else begin
                    iter  <= IDX_W'(1);
                    state <= ST_ITER;
                  end
                end
                OP_NEXT: begin
                  if (iter < total) begin
                    iter  <= iter + 1'b1;
                    state <= ST_ITER;
                  end else begin
                    state <= ST_RESP;
                  end
                end
                OP_CLEAR: begin
                  total    <= '0;
                  iter     <= '0;
                  sweep    <= '0;
                  clr_resp <= 1'b1;
                  state    <= ST_CLEAR;
                end
                default: begin
                  state <= ST_RESP;
                end
              endcase
            end
          end
          ST_HEAD, ST_WALK: begin
            head <= head_now;
            if (hit) begin
              res.found     <= 1'b1;
              res.value_out <= 32'(ent_val);
              state         <= ST_RESP;
            end else if (walk_go) begin
              state <= ST_WALK;
            end else begin
              // Key not in its chain: a find misses, an add inserts or overflows.
              if (cmd.op == OP_ADD) begin
                if (full) begin
                  res.status <= 1'b1;
                end else begin
                  total         <= total + 1'b1;
                  res.found     <= 1'b1;
                  res.value_out <= 32'(cmd.value[VALUE_BITS-1:0]);
                end
              end
              state <= ST_RESP;
            end
          end
          ST_ITER: begin
            res.found     <= 1'b1;
            res.key_out   <= 64'(ent_key);
            res.value_out <= 32'(ent_val);
            state         <= ST_RESP;
          end
          ST_RESP: begin
            if (res_send) begin
              state <= ST_IDLE;
            end
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/core/chained_hash_map_find_add_unit.sv =====
// From input transfer to result valid: find and find-or-add read the bucket head, then one
// chain entry per entry visited; first and next read one entry; clear sweeps all buckets.
// Throughput: one item at a time in the back end; the command queue holds up to two more;
// each chain walk step waits on a registered bucket-head or entry memory read.
// Reset (synchronous, active high) clears control state and then sweeps the bucket heads,
// during which no input transfer is taken; a key_bytes write does the same.
module chained_hash_map_find_add_unit import chm_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int BUCKETS    = BUCKETS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  chm_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output chm_out_t    out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  logic [10:0] capacity_limit;
  logic [3:0]  key_bytes;
  logic        cfg_clear;
  logic        clearing;
  logic        cmd_valid;
  logic        cmd_pop;
  chm_cmd_t    cmd;

  // Configuration registers; a key width write empties the map.
  assign cfg_clear = cfg_we && (cfg_index == CFG_KEY_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_LIMIT_RST;
      key_bytes      <= KEY_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY:  capacity_limit <= cfg_data;
        CFG_KEY_BYTES: key_bytes      <= cfg_data[3:0];
        default:       capacity_limit <= capacity_limit;
      endcase
    end
  end

  chm_front #(.BUCKETS(BUCKETS), .KEY_BITS(KEY_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .key_bytes (key_bytes),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  chm_back #(
    .CAPACITY   (CAPACITY),
    .BUCKETS    (BUCKETS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_clear      (cfg_clear),
    .capacity_limit (capacity_limit),
    .cmd_valid      (cmd_valid),
    .q_cmd          (cmd),
    .cmd_pop        (cmd_pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule
